// ===== design/calendar_date_stepper_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the calendar date stepper
// Shared concurrent checks, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_TOP_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_TOP_ASSERT_SVH

// Property must hold at every edge out of reset.
`define CDS_ASSERT_ALWAYS(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: invariant violated");

// Same-cycle implication.
`define CDS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// Next-cycle implication.
`define CDS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

// ===== design/cds_pkg.sv =====
// ---------------------------------------------------------------------------
// cds_pkg
// Types, constants and calendar helpers for the date stepper.
// ---------------------------------------------------------------------------
package cds_pkg;

  // Input command codes
  localparam logic [2:0] CMD_SET        = 3'd0;
  localparam logic [2:0] CMD_NEXT_DAY   = 3'd1;
  localparam logic [2:0] CMD_PREV_DAY   = 3'd2;
  localparam logic [2:0] CMD_NEXT_MONTH = 3'd3;
  localparam logic [2:0] CMD_PREV_MONTH = 3'd4;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [6:0]  R100_MAX  = 7'd99;

  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  // Jan 1 weekday = (Y + 8 + Y/4 - Y/100 + Y/400) mod 7, Y = year + 399
  localparam logic [8:0]  DOW_YEAR_OFS = 9'd399;
  localparam logic [3:0]  DOW_BIAS     = 4'd8;

  // Reset date 1 Jan 2000 (a Saturday)
  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [13:0] RESET_YEAR  = 14'd2000;
  localparam logic [6:0]  RESET_R100  = 7'd0;
  localparam logic [1:0]  RESET_CENT  = 2'd0;
  localparam logic [2:0]  RESET_JAN1  = 3'd6;

  typedef enum logic [2:0] {
    OP_SET,
    OP_REJECT,
    OP_NEXT_DAY,
    OP_PREV_DAY,
    OP_NEXT_MONTH,
    OP_PREV_MONTH,
    OP_NOP
  } op_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    op_t         op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  r100;   // year mod 100
    logic [1:0]  cent;   // (year / 100) mod 4
    logic [2:0]  jan1;   // weekday of Jan 1
  } entry_t;

  function automatic logic leap_of(input logic [1:0] low2, input logic [6:0] r100,
                                   input logic [1:0] cent);
    leap_of = (low2 == 2'd0) && ((r100 != 7'd0) || (cent == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    case (m)
      MONTH_FEB:                  days_in = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    days_in = 5'd30;
      default:                    days_in = 5'd31;
    endcase
  endfunction

endpackage

// ===== design/cds_cmd_if.sv =====
// ---------------------------------------------------------------------------
// cds_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ---------------------------------------------------------------------------
interface cds_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [4:0]  set_day;
  logic [3:0]  set_month;
  logic [13:0] set_year;

  modport source(output valid, command, set_day, set_month, set_year, input ready);
  modport sink(input valid, command, set_day, set_month, set_year, output ready);
endinterface

// ===== design/cds_res_if.sv =====
// ---------------------------------------------------------------------------
// cds_res_if
// Result channel: valid/ready handshake with the date result payload.
// ---------------------------------------------------------------------------
interface cds_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [13:0] cur_year;
  logic [4:0]  month_length;
  logic [2:0]  first_weekday;
  logic        leap_year;
  logic        error;

  modport source(output valid, cur_day, cur_month, cur_year, month_length,
                 first_weekday, leap_year, error, input ready);
  modport sink(input valid, cur_day, cur_month, cur_year, month_length,
               first_weekday, leap_year, error, output ready);
endinterface

// ===== design/calendar_date_stepper_top.sv =====
// Path from command accept to result valid: the front register loads at the
//   accept edge, then the queue slot is written, then execute into the output
//   register; a full queue or an untaken result can hold an item in between.
// Throughput: one command per cycle while the queue has room and results are
//   taken; the back-end update is combinational, so items follow back to back.
// Reset (rst, synchronous): date returns to 1 Jan 2000, queue and pipeline
//   empty; no result is pending afterwards.
// ---------------------------------------------------------------------------
// calendar_date_stepper_top
// Gregorian date counter: set, next/previous day, next/previous month.
// ---------------------------------------------------------------------------
//
// Structure:
//   cds_front  - accepts a command, classifies it, and for the set command
//                splits the year into mod 100 / century mod 4 (reciprocal
//                multiply by 1/100, registered) and derives the weekday of
//                Jan 1 and whether the requested date exists. Invalid set
//                dates become a reject op here.
//   cds_queue  - short FIFO; decouples front-end stalls from back-end stalls.
//   cds_back   - owns the date. Keeps year mod 100, century mod 4 and the
//                Jan 1 weekday alongside the year, so year carries only need
//                steps by one and a mod-7 add. Leap flag, month length and the
//                month's first weekday follow from that in the same cycle.
//                Year bound hits (past 9999 or before year 0) hold the date
//                and flag an error. Results sit in an output register; a new
//                item is taken only while it is empty or its result is read.
module calendar_date_stepper_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  cds_cmd_if.sink   cmd,
  cds_res_if.source res
);

  logic            push;
  cds_pkg::entry_t push_entry;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  cds_pkg::entry_t q_head;

  cds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  cds_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_head),
    .pop     (pop),
    .res     (res)
  );

endmodule

// ===== design/cds_front.sv =====
// ---------------------------------------------------------------------------
// cds_front
// Accepts commands, classifies them and pre-computes set-date year facts.
// ---------------------------------------------------------------------------
module cds_front (
  input  logic           clk,
  input  logic           rst,
  cds_cmd_if.sink        cmd,
  input  logic           q_full,
  output logic           push,
  output cds_pkg::entry_t push_entry
);

  // Stage A registers
  logic                a_valid;
  cds_pkg::op_t        a_op;
  logic [4:0]          a_day;
  logic [3:0]          a_month;
  logic [13:0]         a_year;
  logic [26:0]         a_prod_year;
  logic [27:0]         a_prod_ofs;

  cds_pkg::op_t        op_in;
  logic [14:0]         ofs_in;
  logic                adv;

  logic [7:0]          q_year;
  logic [8:0]          q_ofs;
  logic [6:0]          r100;
  logic                leap;
  logic [14:0]         ofs_year;
  logic [15:0]         dow_sum;
  logic                date_ok;

  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  assign adv       = !a_valid || !q_full;
  assign cmd.ready = adv;
  assign push      = a_valid && !q_full;
  assign ofs_in    = 15'(cmd.set_year) + 15'(cds_pkg::DOW_YEAR_OFS);

  always_comb begin
    case (cmd.command)
      cds_pkg::CMD_SET:        op_in = cds_pkg::OP_SET;
      cds_pkg::CMD_NEXT_DAY:   op_in = cds_pkg::OP_NEXT_DAY;
      cds_pkg::CMD_PREV_DAY:   op_in = cds_pkg::OP_PREV_DAY;
      cds_pkg::CMD_NEXT_MONTH: op_in = cds_pkg::OP_NEXT_MONTH;
      cds_pkg::CMD_PREV_MONTH: op_in = cds_pkg::OP_PREV_MONTH;
      default:                 op_in = cds_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= cmd.valid;
    end
    if (adv) begin
      a_op        <= op_in;
      a_day       <= cmd.set_day;
      a_month     <= cmd.set_month;
      a_year      <= cmd.set_year;
      a_prod_year <= 27'(cmd.set_year) * 27'(cds_pkg::RECIP_100);
      a_prod_ofs  <= 28'(ofs_in) * 28'(cds_pkg::RECIP_100);
    end
  end

  // Stage B: year decomposition, validity, weekday of Jan 1
  always_comb begin
    q_year   = a_prod_year[26:cds_pkg::RECIP_SHIFT];
    q_ofs    = a_prod_ofs[27:cds_pkg::RECIP_SHIFT];
    r100     = 7'(a_year - 14'(q_year) * 14'd100);
    leap     = cds_pkg::leap_of(a_year[1:0], r100, q_year[1:0]);
    ofs_year = 15'(a_year) + 15'(cds_pkg::DOW_YEAR_OFS);
    dow_sum  = 16'(ofs_year) + 16'(cds_pkg::DOW_BIAS) + 16'(ofs_year[14:2])
             - 16'(q_ofs) + 16'(q_ofs[8:2]);
    date_ok  = (a_month inside {[4'd1:4'd12]}) && (a_year <= cds_pkg::YEAR_MAX)
            && (a_day >= cds_pkg::DAY_FIRST) && (a_day <= cds_pkg::days_in(a_month, leap));

    push_entry.op    = ((a_op == cds_pkg::OP_SET) && !date_ok) ? cds_pkg::OP_REJECT : a_op;
    push_entry.day   = a_day;
    push_entry.month = a_month;
    push_entry.year  = a_year;
    push_entry.r100  = r100;
    push_entry.cent  = q_year[1:0];
    push_entry.jan1  = mod7(dow_sum);
  end

endmodule

// ===== design/cds_queue.sv =====
// ---------------------------------------------------------------------------
// cds_queue
// Small FIFO of classified items between front and back.
// ---------------------------------------------------------------------------
module cds_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cds_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output cds_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cds_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== design/cds_back.sv =====
// ---------------------------------------------------------------------------
// cds_back
// Holds the date; one item per cycle unless stalled; registers the result.
// ---------------------------------------------------------------------------
`include "calendar_date_stepper_top_assert.svh"

module cds_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  cds_pkg::entry_t q_entry,
  output logic            pop,
  cds_res_if.source       res
);

  // Date state plus year decomposition
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [6:0]  r100;
  logic [1:0]  cent;
  logic [2:0]  jan1;

  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [13:0] year_next;
  logic [6:0]  r100_next;
  logic [1:0]  cent_next;
  logic [2:0]  jan1_next;
  logic        leap_next;
  logic        err_next;

  logic        leap_cur;
  logic [4:0]  len_cur;
  logic [3:0]  m_up;
  logic [3:0]  m_dn;
  logic [4:0]  len_up;
  logic [4:0]  len_dn;

  logic [13:0] y_inc;
  logic [6:0]  r_inc;
  logic [1:0]  c_inc;
  logic        leap_inc;
  logic [2:0]  jan1_inc;
  logic [13:0] y_dec;
  logic [6:0]  r_dec;
  logic [1:0]  c_dec;
  logic        leap_dec;
  logic [2:0]  jan1_dec;

  logic [4:0]  len_next;
  logic [2:0]  dow_next;

  // Output register
  logic        out_valid;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic [4:0]  out_len;
  logic [2:0]  out_dow;
  logic        out_leap;
  logic        out_err;

  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = 4'(a) + 4'(b);
    add_mod7 = (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  // Weekday offset of the month's first day from Jan 1, common year
  function automatic logic [2:0] month_ofs(input logic [3:0] m);
    case (m)
      4'd2, 4'd3, 4'd11: month_ofs = 3'd3;
      4'd4, 4'd7:        month_ofs = 3'd6;
      4'd5:              month_ofs = 3'd1;
      4'd6:              month_ofs = 3'd4;
      4'd8:              month_ofs = 3'd2;
      4'd9, 4'd12:       month_ofs = 3'd5;
      default:           month_ofs = 3'd0;
    endcase
  endfunction

  assign pop = q_valid && (!out_valid || res.ready);

  always_comb begin
    leap_cur = cds_pkg::leap_of(year[1:0], r100, cent);
    len_cur  = cds_pkg::days_in(month, leap_cur);
    m_up     = month + 4'd1;
    m_dn     = month - 4'd1;
    len_up   = cds_pkg::days_in(m_up, leap_cur);
    len_dn   = cds_pkg::days_in(m_dn, leap_cur);

    y_inc    = year + 14'd1;
    r_inc    = (r100 == cds_pkg::R100_MAX) ? 7'd0 : r100 + 7'd1;
    c_inc    = (r100 == cds_pkg::R100_MAX) ? cent + 2'd1 : cent;
    leap_inc = cds_pkg::leap_of(y_inc[1:0], r_inc, c_inc);
    jan1_inc = add_mod7(jan1, leap_cur ? 3'd2 : 3'd1);

    y_dec    = year - 14'd1;
    r_dec    = (r100 == 7'd0) ? cds_pkg::R100_MAX : r100 - 7'd1;
    c_dec    = (r100 == 7'd0) ? cent - 2'd1 : cent;
    leap_dec = cds_pkg::leap_of(y_dec[1:0], r_dec, c_dec);
    // step back 2 (or 1) days: add 5 (or 6) mod 7
    jan1_dec = add_mod7(jan1, leap_dec ? 3'd5 : 3'd6);
  end

  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    r100_next  = r100;
    cent_next  = cent;
    jan1_next  = jan1;
    leap_next  = leap_cur;
    err_next   = 1'b0;

    case (q_entry.op)
      cds_pkg::OP_SET: begin
        day_next   = q_entry.day;
        month_next = q_entry.month;
        year_next  = q_entry.year;
        r100_next  = q_entry.r100;
        cent_next  = q_entry.cent;
        jan1_next  = q_entry.jan1;
        leap_next  = cds_pkg::leap_of(q_entry.year[1:0], q_entry.r100, q_entry.cent);
      end
      cds_pkg::OP_REJECT: begin
        err_next = 1'b1;
      end
      cds_pkg::OP_NEXT_DAY: begin
        if (day < len_cur) begin
          day_next = day + 5'd1;
        end else if (month < cds_pkg::MONTH_DEC) begin
          day_next   = cds_pkg::DAY_FIRST;
          month_next = m_up;
        end else if (year >= cds_pkg::YEAR_MAX) begin
          err_next = 1'b1;
        end else begin
          day_next   = cds_pkg::DAY_FIRST;
          month_next = cds_pkg::MONTH_JAN;
          year_next  = y_inc;
          r100_next  = r_inc;
          cent_next  = c_inc;
          jan1_next  = jan1_inc;
          leap_next  = leap_inc;
        end
      end
      cds_pkg::OP_PREV_DAY: begin
        if (day > cds_pkg::DAY_FIRST) begin
          day_next = day - 5'd1;
        end else if (month > cds_pkg::MONTH_JAN) begin
          day_next   = len_dn;
          month_next = m_dn;
        end else if (year == 14'd0) begin
          err_next = 1'b1;
        end else begin
          day_next   = cds_pkg::days_in(cds_pkg::MONTH_DEC, leap_dec);
          month_next = cds_pkg::MONTH_DEC;
          year_next  = y_dec;
          r100_next  = r_dec;
          cent_next  = c_dec;
          jan1_next  = jan1_dec;
          leap_next  = leap_dec;
        end
      end
      cds_pkg::OP_NEXT_MONTH: begin
        if (month < cds_pkg::MONTH_DEC) begin
          month_next = m_up;
          day_next   = (day > len_up) ? len_up : day;
        end else if (year >= cds_pkg::YEAR_MAX) begin
          err_next = 1'b1;
        end else begin
          // January is 31 days long: no clamp
          month_next = cds_pkg::MONTH_JAN;
          year_next  = y_inc;
          r100_next  = r_inc;
          cent_next  = c_inc;
          jan1_next  = jan1_inc;
          leap_next  = leap_inc;
        end
      end
      cds_pkg::OP_PREV_MONTH: begin
        if (month > cds_pkg::MONTH_JAN) begin
          month_next = m_dn;
          day_next   = (day > len_dn) ? len_dn : day;
        end else if (year == 14'd0) begin
          err_next = 1'b1;
        end else begin
          month_next = cds_pkg::MONTH_DEC;
          year_next  = y_dec;
          r100_next  = r_dec;
          cent_next  = c_dec;
          jan1_next  = jan1_dec;
          leap_next  = leap_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    len_next = cds_pkg::days_in(month_next, leap_next);
    dow_next = add_mod7(add_mod7(jan1_next, month_ofs(month_next)),
                        (leap_next && (month_next > cds_pkg::MONTH_FEB)) ? 3'd1 : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day       <= cds_pkg::RESET_DAY;
      month     <= cds_pkg::RESET_MONTH;
      year      <= cds_pkg::RESET_YEAR;
      r100      <= cds_pkg::RESET_R100;
      cent      <= cds_pkg::RESET_CENT;
      jan1      <= cds_pkg::RESET_JAN1;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        day       <= day_next;
        month     <= month_next;
        year      <= year_next;
        r100      <= r100_next;
        cent      <= cent_next;
        jan1      <= jan1_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      out_day   <= day_next;
      out_month <= month_next;
      out_year  <= year_next;
      out_len   <= len_next;
      out_dow   <= dow_next;
      out_leap  <= leap_next;
      out_err   <= err_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.cur_day       = out_day;
  assign res.cur_month     = out_month;
  assign res.cur_year      = out_year;
  assign res.month_length  = out_len;
  assign res.first_weekday = out_dow;
  assign res.leap_year     = out_leap;
  assign res.error         = out_err;

  `CDS_ASSERT_ALWAYS(a_month_range, clk, rst, (month >= cds_pkg::MONTH_JAN) && (month <= cds_pkg::MONTH_DEC))
  `CDS_ASSERT_ALWAYS(a_day_range, clk, rst, (day >= cds_pkg::DAY_FIRST) && (day <= len_cur))
  `CDS_ASSERT_NEXT(a_reject_holds, clk, rst, pop && (q_entry.op == cds_pkg::OP_REJECT), out_err && (day == $past(day)) && (year == $past(year)))

endmodule
